// ----- rtl/wia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_pkg: shared types and constants of the 256-bit integer ALU
// Operand and result widths, operation codes and the request and response
// words that pass between the pipeline and the datapath.
// ----------------------------------------------------------------------------
package wia_pkg;

  localparam int LIMB_W   = 64;
  localparam int NUM_LIMB = 4;
  localparam int WORD_W   = LIMB_W * NUM_LIMB;
  localparam int OPCODE_W = 4;
  localparam int AMT_W    = 9;
  localparam int BITPOS_W = $clog2(WORD_W);

  // Operation codes; the codes left over act as pass.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PASS   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_AND    = 4'd3,
    OP_OR     = 4'd4,
    OP_XOR    = 4'd5,
    OP_NOT    = 4'd6,
    OP_SHR    = 4'd7,
    OP_SHL    = 4'd8,
    OP_INC    = 4'd9,
    OP_DEC    = 4'd10,
    OP_GETBIT = 4'd11,
    OP_SETBIT = 4'd12
  } op_t;

  // One input word, operands flattened to full width.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
    logic [AMT_W-1:0]    amount;
    logic                bit_value;
  } wia_req_t;

  // One result word.
  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              a_less;
    logic              a_equal;
    logic              a_greater;
    logic              bit_out;
  } wia_rsp_t;

endpackage

// ----- rtl/wia_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_in_if: operand channel of the 256-bit integer ALU
// Valid/ready channel carrying the opcode, both operands as limbs, the
// shift amount or bit position, and the value for a bit write.
// ----------------------------------------------------------------------------
interface wia_in_if import wia_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [LIMB_W-1:0]   a_limb3;
  logic [LIMB_W-1:0]   a_limb2;
  logic [LIMB_W-1:0]   a_limb1;
  logic [LIMB_W-1:0]   a_limb0;
  logic [LIMB_W-1:0]   b_limb3;
  logic [LIMB_W-1:0]   b_limb2;
  logic [LIMB_W-1:0]   b_limb1;
  logic [LIMB_W-1:0]   b_limb0;
  logic [AMT_W-1:0]    amount;
  logic                bit_value;

  modport source (
    output valid, opcode, a_limb3, a_limb2, a_limb1, a_limb0,
           b_limb3, b_limb2, b_limb1, b_limb0, amount, bit_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, a_limb3, a_limb2, a_limb1, a_limb0,
           b_limb3, b_limb2, b_limb1, b_limb0, amount, bit_value,
    output ready
  );

endinterface

// ----- rtl/wia_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_out_if: result channel of the 256-bit integer ALU
// Valid/ready channel carrying the result limbs, the compare flags and the
// selected bit of operand A.
// ----------------------------------------------------------------------------
interface wia_out_if import wia_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] r_limb3;
  logic [LIMB_W-1:0] r_limb2;
  logic [LIMB_W-1:0] r_limb1;
  logic [LIMB_W-1:0] r_limb0;
  logic              a_less;
  logic              a_equal;
  logic              a_greater;
  logic              bit_out;

  modport source (
    output valid, r_limb3, r_limb2, r_limb1, r_limb0,
           a_less, a_equal, a_greater, bit_out,
    input  ready
  );

  modport sink (
    input  valid, r_limb3, r_limb2, r_limb1, r_limb0,
           a_less, a_equal, a_greater, bit_out,
    output ready
  );

endinterface

// ----- rtl/wide_integer_alu_256.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_integer_alu_256: 256-bit unsigned integer ALU
// Two-register pipeline around a single-pass combinational datapath.
// ----------------------------------------------------------------------------
// The block takes one operand word per clock cycle while the result side is
// not stalled and returns one result word for each, in order. Each word passes
// an input register, the combinational datapath (one 256-bit adder, a barrel
// shifter and the compare) and a result register; both registers advance
// independently, so a new word is taken while a finished result still waits to
// be collected, and a stall on the result side backs up through the two
// registers before in_ch.ready drops.
// ----------------------------------------------------------------------------
module wide_integer_alu_256 import wia_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wia_in_if.sink    in_ch,
  wia_out_if.source out_ch
);

  logic     s1_valid_r;
  wia_req_t s1_req_r;
  logic     out_valid_r;
  wia_rsp_t out_rsp_r;
  wia_rsp_t out_rsp_nxt;
  logic     s1_ready;
  logic     s2_ready;
  logic     in_take;
  logic     s2_take;

  // Pipeline flow control: each register refills when empty or draining.
  assign s2_ready    = !out_valid_r || out_ch.ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_take     = in_ch.valid && s1_ready;
  assign s2_take     = s1_valid_r && s2_ready;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Input register: operand limbs packed into full-width words.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.opcode    <= in_ch.opcode;
      s1_req_r.a         <= {in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0};
      s1_req_r.b         <= {in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0};
      s1_req_r.amount    <= in_ch.amount;
      s1_req_r.bit_value <= in_ch.bit_value;
    end
  end

  wia_datapath u_datapath (
    .req (s1_req_r),
    .rsp (out_rsp_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.r_limb3   = out_rsp_r.result[4*LIMB_W-1:3*LIMB_W];
  assign out_ch.r_limb2   = out_rsp_r.result[3*LIMB_W-1:2*LIMB_W];
  assign out_ch.r_limb1   = out_rsp_r.result[2*LIMB_W-1:LIMB_W];
  assign out_ch.r_limb0   = out_rsp_r.result[LIMB_W-1:0];
  assign out_ch.a_less    = out_rsp_r.a_less;
  assign out_ch.a_equal   = out_rsp_r.a_equal;
  assign out_ch.a_greater = out_rsp_r.a_greater;
  assign out_ch.bit_out   = out_rsp_r.bit_out;

`ifndef SYNTHESIS
  // Exactly one compare flag is set on every delivered result.
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_rsp_r.a_less, out_rsp_r.a_equal, out_rsp_r.a_greater}))
    else $error("compare flags not one-hot");

  // A word in the input register moves on whenever the result side can take it.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    s2_take |=> out_valid_r)
    else $error("word lost between input and result register");

  // An out-of-range position never reads a set bit.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_take && (s1_req_r.amount >= AMT_W'(WORD_W))) |=> !out_rsp_r.bit_out)
    else $error("bit read beyond the word");

  // A full pipeline with a stalled result side takes no new word.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_take)
    else $error("word accepted into a full pipeline");
`endif

endmodule

// ----- rtl/wia_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_datapath: combinational datapath of the 256-bit integer ALU
// One shared adder for add, subtract, increment and decrement, a barrel
// shifter, the bitwise operations, a single-bit read and write, and the
// unsigned compare of A against B.
// ----------------------------------------------------------------------------
module wia_datapath import wia_pkg::*; (
  input  wia_req_t req,
  output wia_rsp_t rsp
);

  logic [WORD_W-1:0]   add_y;
  logic                add_cin;
  logic [WORD_W-1:0]   add_sum;
  logic [BITPOS_W-1:0] bit_pos;
  logic                pos_valid;
  logic [WORD_W-1:0]   bit_mask;
  logic [WORD_W-1:0]   shr_val;
  logic [WORD_W-1:0]   shl_val;
  logic [WORD_W-1:0]   alu_result;

  // The position is in range only below the word width; beyond that shifts
  // clear the word and bit accesses see nothing.
  assign pos_valid = (req.amount < AMT_W'(WORD_W));
  assign bit_pos   = req.amount[BITPOS_W-1:0];
  assign bit_mask  = {{(WORD_W-1){1'b0}}, 1'b1} << bit_pos;
  assign shr_val   = pos_valid ? (req.a >> bit_pos) : '0;
  assign shl_val   = pos_valid ? (req.a << bit_pos) : '0;

  // Second adder operand and carry in, chosen by the operation.
  always_comb begin
    unique case (req.opcode)
      OP_ADD: begin
        add_y   = req.b;
        add_cin = 1'b0;
      end
      OP_SUB: begin
        add_y   = ~req.b;
        add_cin = 1'b1;
      end
      OP_INC: begin
        add_y   = '0;
        add_cin = 1'b1;
      end
      OP_DEC: begin
        add_y   = '1;
        add_cin = 1'b0;
      end
      default: begin
        add_y   = req.b;
        add_cin = 1'b0;
      end
    endcase
  end

  // The sum wraps modulo 2 to the power of the word width.
  assign add_sum = req.a + add_y + WORD_W'(add_cin);

  // Result selection.
  always_comb begin
    unique case (req.opcode)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: alu_result = add_sum;
      OP_AND:    alu_result = req.a & req.b;
      OP_OR:     alu_result = req.a | req.b;
      OP_XOR:    alu_result = req.a ^ req.b;
      OP_NOT:    alu_result = ~req.a;
      OP_SHR:    alu_result = shr_val;
      OP_SHL:    alu_result = shl_val;
      OP_SETBIT: begin
        if (!pos_valid) begin
          alu_result = req.a;
        end else if (req.bit_value) begin
          alu_result = req.a | bit_mask;
        end else begin
          alu_result = req.a & ~bit_mask;
        end
      end
      default:   alu_result = req.a;
    endcase
  end

  assign rsp.result = alu_result;

  // Flags are produced for every operation.
  assign rsp.a_less    = (req.a < req.b);
  assign rsp.a_equal   = (req.a == req.b);
  assign rsp.a_greater = (req.a > req.b);
  assign rsp.bit_out   = pos_valid & req.a[bit_pos];

endmodule

// ----- tb/sv/tb_wide_integer_alu_256.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wide_integer_alu_256: self-checking bench for the 256-bit integer ALU
// A short table of directed words followed by about 1400 random words is
// sent over the operand channel with random gaps. The result channel is
// stalled at random. Every result word is checked, field by field, against
// the expected word, in order.
// ----------------------------------------------------------------------------
module tb_wide_integer_alu_256;
  import wia_pkg::*;

  // Opcodes with no operation of their own; the block treats them as pass.
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO  = 4'd13;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_MID = 4'd14;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI  = 4'd15;

  localparam int RANDOM_WORDS   = 1400;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 16;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] ZERO     = {WORD_W{1'b0}};
  localparam logic [WORD_W-1:0] TOP_BIT  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] PAT_A    = {64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                                            64'h8000000000000001, 64'h00000000FFFFFFFF};
  localparam logic [WORD_W-1:0] PAT_B    = {64'hF0F0F0F0F0F0F0F0, 64'h0F0F0F0F0F0F0F0F,
                                            64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFF00000001};
  localparam logic [WORD_W-1:0] LOW_LIMB = {{(WORD_W-LIMB_W){1'b0}}, {LIMB_W{1'b1}}};

  typedef struct {
    wia_req_t req;
    bit       known;
    wia_rsp_t rsp;
  } alu_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  wia_in_if  in_ch ();
  wia_out_if out_ch ();

  wide_integer_alu_256 u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_row_t    directed_rows[$];
  wia_rsp_t    expected_q[$];
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned burst_left    = 0;
  int unsigned sink_left     = 0;
  logic        sink_open     = 1'b1;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one line per mismatch and counts every one.
  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Expected result word for one operand word.
  function automatic wia_rsp_t alu_predict(input wia_req_t w);
    wia_rsp_t          p;
    logic [WORD_W-1:0] r;
    logic              in_range;
    logic [BITPOS_W-1:0] pos;
    in_range    = (w.amount < WORD_W);
    pos         = w.amount[BITPOS_W-1:0];
    p.a_less    = (w.a < w.b);
    p.a_equal   = (w.a == w.b);
    p.a_greater = (w.a > w.b);
    p.bit_out   = in_range ? w.a[pos] : 1'b0;
    r = w.a;
    case (w.opcode)
      OP_ADD:    r = w.a + w.b;
      OP_SUB:    r = w.a - w.b;
      OP_AND:    r = w.a & w.b;
      OP_OR:     r = w.a | w.b;
      OP_XOR:    r = w.a ^ w.b;
      OP_NOT:    r = ~w.a;
      OP_SHR:    r = in_range ? (w.a >> w.amount) : ZERO;
      OP_SHL:    r = in_range ? (w.a << w.amount) : ZERO;
      OP_INC:    r = w.a + 1'b1;
      OP_DEC:    r = w.a - 1'b1;
      OP_SETBIT: begin
        if (in_range) r[pos] = w.bit_value;
      end
      default:   r = w.a;
    endcase
    p.result = r;
    return p;
  endfunction

  function automatic wia_req_t make_req(input logic [OPCODE_W-1:0] op,
                                        input logic [WORD_W-1:0] a,
                                        input logic [WORD_W-1:0] b,
                                        input logic [AMT_W-1:0] amt,
                                        input logic bv);
    wia_req_t w;
    w.opcode    = op;
    w.a         = a;
    w.b         = b;
    w.amount    = amt;
    w.bit_value = bv;
    return w;
  endfunction

  // Table row whose result comes from the predictor.
  function automatic void row_pred(input logic [OPCODE_W-1:0] op,
                                   input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                   input logic [AMT_W-1:0] amt, input logic bv);
    alu_row_t row;
    row.req   = make_req(op, a, b, amt, bv);
    row.known = 1'b0;
    row.rsp   = '0;
    directed_rows.push_back(row);
  endfunction

  // Table row with its result written out by hand.
  function automatic void row_known(input logic [OPCODE_W-1:0] op,
                                    input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                    input logic [AMT_W-1:0] amt, input logic bv,
                                    input logic [WORD_W-1:0] res,
                                    input logic lt, input logic eq, input logic gt,
                                    input logic bo);
    alu_row_t row;
    row.req            = make_req(op, a, b, amt, bv);
    row.known          = 1'b1;
    row.rsp.result     = res;
    row.rsp.a_less     = lt;
    row.rsp.a_equal    = eq;
    row.rsp.a_greater  = gt;
    row.rsp.bit_out    = bo;
    directed_rows.push_back(row);
  endfunction

  // Length of a pause: mostly short, now and then long.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Gap before the next operand word, with occasional stretches of none.
  function automatic int unsigned gap_len();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(50, 150);
      return 0;
    end
    if ($urandom_range(0, 99) < 60) return 0;
    return pause_len();
  endfunction

  function automatic logic [LIMB_W-1:0] rand_limb();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1;
      3:       return {1'b1, {(LIMB_W-1){1'b0}}};
      4:       return {LIMB_W{1'b1}} >> $urandom_range(1, LIMB_W - 1);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {rand_limb(), rand_limb(), rand_limb(), rand_limb()};
  endfunction

  // Random operand word, with B often close to A so that the compare sees
  // ties and differences confined to a single limb.
  function automatic wia_req_t rand_req();
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [AMT_W-1:0]  amt;
    int unsigned       r;
    a = rand_word();
    case ($urandom_range(0, 9))
      0, 1: b = a;
      2: begin
        b = a;
        b[$urandom_range(0, NUM_LIMB - 1) * LIMB_W +: LIMB_W] = rand_limb();
      end
      3:       b = a + 1'b1;
      4:       b = a - 1'b1;
      default: b = rand_word();
    endcase
    r = $urandom_range(0, 99);
    if (r < 10)      amt = AMT_W'(WORD_W);
    else if (r < 18) amt = AMT_W'($urandom_range(WORD_W + 1, (1 << AMT_W) - 1));
    else if (r < 30) amt = AMT_W'(($urandom_range(0, NUM_LIMB - 1) * LIMB_W)
                                  + ($urandom_range(0, 1) ? LIMB_W - 1 : 0));
    else             amt = AMT_W'($urandom_range(0, WORD_W - 1));
    return make_req(OPCODE_W'($urandom_range(int'(OP_PASS), int'(OP_UNUSED_HI))), a, b,
                    amt, 1'($urandom_range(0, 1)));
  endfunction

  // Sends one operand word and files its expected result on acceptance.
  task automatic send_word(input wia_req_t w, input bit known, input wia_rsp_t want);
    int unsigned gap;
    gap = gap_len();
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.opcode    <= w.opcode;
    in_ch.a_limb3   <= w.a[3*LIMB_W +: LIMB_W];
    in_ch.a_limb2   <= w.a[2*LIMB_W +: LIMB_W];
    in_ch.a_limb1   <= w.a[1*LIMB_W +: LIMB_W];
    in_ch.a_limb0   <= w.a[0*LIMB_W +: LIMB_W];
    in_ch.b_limb3   <= w.b[3*LIMB_W +: LIMB_W];
    in_ch.b_limb2   <= w.b[2*LIMB_W +: LIMB_W];
    in_ch.b_limb1   <= w.b[1*LIMB_W +: LIMB_W];
    in_ch.b_limb0   <= w.b[0*LIMB_W +: LIMB_W];
    in_ch.amount    <= w.amount;
    in_ch.bit_value <= w.bit_value;
    in_ch.valid     <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(known ? want : alu_predict(w));
  endtask

  // Result side: ready held high or low for random stretches.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_open = !sink_open;
      if (sink_open) begin
        sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
      end else begin
        sink_left = pause_len();
      end
    end
    sink_left--;
    out_ch.ready <= sink_open;
  end

  // Checks each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    wia_rsp_t got;
    wia_rsp_t want;
    logic [3:0] got_flags;
    logic [3:0] want_flags;
    string      flag_name [4];
    flag_name = '{"bit_out", "a_greater", "a_equal", "a_less"};
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result    = {out_ch.r_limb3, out_ch.r_limb2, out_ch.r_limb1, out_ch.r_limb0};
      got.a_less    = out_ch.a_less;
      got.a_equal   = out_ch.a_equal;
      got.a_greater = out_ch.a_greater;
      got.bit_out   = out_ch.bit_out;
      if (expected_q.size() == 0) begin
        note_error($sformatf("result word %0d arrived with none expected", results_seen));
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < NUM_LIMB; i++) begin
          if (got.result[i*LIMB_W +: LIMB_W] !== want.result[i*LIMB_W +: LIMB_W]) begin
            note_error($sformatf("word %0d r_limb%0d: got %h, expected %h", results_seen, i,
                                 got.result[i*LIMB_W +: LIMB_W],
                                 want.result[i*LIMB_W +: LIMB_W]));
          end
        end
        got_flags  = {got.a_less, got.a_equal, got.a_greater, got.bit_out};
        want_flags = {want.a_less, want.a_equal, want.a_greater, want.bit_out};
        for (int i = 0; i < 4; i++) begin
          if (got_flags[i] !== want_flags[i]) begin
            note_error($sformatf("word %0d %s: got %b, expected %b", results_seen,
                                 flag_name[i], got_flags[i], want_flags[i]));
          end
        end
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR @%0t: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("** wide_integer_alu_256: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random words, drain.
  initial begin
    wia_req_t w;
    wia_rsp_t none;
    none = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_PASS;
    in_ch.a_limb3   = '0;
    in_ch.a_limb2   = '0;
    in_ch.a_limb1   = '0;
    in_ch.a_limb0   = '0;
    in_ch.b_limb3   = '0;
    in_ch.b_limb2   = '0;
    in_ch.b_limb1   = '0;
    in_ch.b_limb0   = '0;
    in_ch.amount    = '0;
    in_ch.bit_value = 1'b0;
    out_ch.ready    = 1'b0;

    // Extremes and error-free corner cases with results read off by hand.
    row_known(OP_PASS,   ZERO,     ZERO,     9'd0,   1'b0, ZERO,
              1'b0, 1'b1, 1'b0, 1'b0);
    row_known(OP_ADD,    ALL_ONES, 256'd1,   9'd0,   1'b0, ZERO,
              1'b0, 1'b0, 1'b1, 1'b1);
    row_known(OP_SUB,    ZERO,     256'd1,   9'd0,   1'b0, ALL_ONES,
              1'b1, 1'b0, 1'b0, 1'b0);
    row_known(OP_INC,    ALL_ONES, ALL_ONES, 9'd255, 1'b0, ZERO,
              1'b0, 1'b1, 1'b0, 1'b1);
    row_known(OP_DEC,    ZERO,     ZERO,     9'd256, 1'b0, ALL_ONES,
              1'b0, 1'b1, 1'b0, 1'b0);
    row_known(OP_NOT,    ZERO,     ALL_ONES, 9'd0,   1'b0, ALL_ONES,
              1'b1, 1'b0, 1'b0, 1'b0);
    // Shifts of the full width or more clear the result; shifts by 255 keep one bit.
    row_known(OP_SHR,    ALL_ONES, ZERO,     9'd256, 1'b0, ZERO,
              1'b0, 1'b0, 1'b1, 1'b0);
    row_known(OP_SHL,    ALL_ONES, ZERO,     9'd511, 1'b1, ZERO,
              1'b0, 1'b0, 1'b1, 1'b0);
    row_known(OP_SHR,    ALL_ONES, ALL_ONES, 9'd255, 1'b0, 256'd1,
              1'b0, 1'b1, 1'b0, 1'b1);
    row_known(OP_SHL,    256'd1,   ZERO,     9'd255, 1'b0, TOP_BIT,
              1'b0, 1'b0, 1'b1, 1'b0);
    // A bit position out of range reads 0 and leaves A alone.
    row_known(OP_GETBIT, ALL_ONES, ZERO,     9'd256, 1'b0, ALL_ONES,
              1'b0, 1'b0, 1'b1, 1'b0);
    row_known(OP_SETBIT, ZERO,     ZERO,     9'd300, 1'b1, ZERO,
              1'b0, 1'b1, 1'b0, 1'b0);
    // Remaining operations and limb boundaries, against the predictor.
    row_pred(OP_ADD,        LOW_LIMB, 256'd1,           9'd64,  1'b0);
    row_pred(OP_SUB,        PAT_A,    PAT_B,            9'd17,  1'b1);
    row_pred(OP_AND,        PAT_A,    PAT_A ^ 256'd1,   9'd1,   1'b0);
    row_pred(OP_OR,         PAT_A,    PAT_B,            9'd127, 1'b1);
    row_pred(OP_XOR,        PAT_B,    PAT_A,            9'd128, 1'b0);
    row_pred(OP_SHR,        PAT_A,    PAT_B,            9'd64,  1'b0);
    row_pred(OP_SHL,        PAT_A,    PAT_B,            9'd128, 1'b0);
    row_pred(OP_SHL,        PAT_B,    PAT_A,            9'd65,  1'b1);
    row_pred(OP_SETBIT,     PAT_A,    PAT_B,            9'd200, 1'b1);
    row_pred(OP_SETBIT,     ALL_ONES, ZERO,             9'd64,  1'b0);
    row_pred(OP_GETBIT,     PAT_A,    PAT_A,            9'd191, 1'b0);
    row_pred(OP_UNUSED_LO,  PAT_A,    PAT_B,            9'd3,   1'b1);
    row_pred(OP_UNUSED_MID, PAT_B,    PAT_A,            9'd192, 1'b0);
    row_pred(OP_UNUSED_HI,  PAT_A,    ZERO,             9'd63,  1'b1);

    // Synchronous reset, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].req, directed_rows[i].known, directed_rows[i].rsp);
    end

    repeat (RANDOM_WORDS) begin
      w = rand_req();
      send_word(w, 1'b0, none);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for the outstanding results, then watch for strays.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** wide_integer_alu_256: PASSED **");
    end else begin
      $display("** wide_integer_alu_256: FAILED **");
    end
    $finish;
  end

endmodule
